@@ rtl/core/lpct_pkg.sv @@
// Shared types and field widths for the LRU page cache tag block.
package lpct_pkg;

   localparam int BYTE_OFFSET_W    = 48;
   localparam int SLOT_W           = 4;
   localparam int OFFSET_IN_PAGE_W = 12;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;   // latch a new request transaction
      logic lookup;    // register tag match and LRU choice
      logic commit;    // update slot state and load the result register
   } cmd_type;

   typedef struct packed {
      logic                          hit;
      logic [SLOT_W-1:0]             slot;
      logic [BYTE_OFFSET_W-1:0]      page_base;
      logic [OFFSET_IN_PAGE_W-1:0]   offset_in_page;
      logic                          fill_needed;
      logic                          evict_valid;
      logic [BYTE_OFFSET_W-1:0]      evicted_page_base;
   } rsp_payload_type;

endpackage

@@ rtl/core/lpct_req_if.sv @@
// Request channel: byte offset with valid/ready handshake.
interface lpct_req_if;
   import lpct_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [BYTE_OFFSET_W-1:0] byte_offset;

   modport source (output valid, output byte_offset, input ready);
   modport sink   (input valid, input byte_offset, output ready);
endinterface

@@ rtl/core/lpct_rsp_if.sv @@
// Result channel: lookup outcome with valid/ready handshake.
interface lpct_rsp_if;
   import lpct_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [SLOT_W-1:0]           slot;
   logic [BYTE_OFFSET_W-1:0]    page_base;
   logic [OFFSET_IN_PAGE_W-1:0] offset_in_page;
   logic                        fill_needed;
   logic                        evict_valid;
   logic [BYTE_OFFSET_W-1:0]    evicted_page_base;

   modport source (output valid, output hit, output slot, output page_base,
                   output offset_in_page, output fill_needed, output evict_valid,
                   output evicted_page_base, input ready);
   modport sink   (input valid, input hit, input slot, input page_base,
                   input offset_in_page, input fill_needed, input evict_valid,
                   input evicted_page_base, output ready);
endinterface

@@ rtl/core/lpct_ctrl.sv @@
// Sequencer for capture, lookup and commit, plus the result valid flag.
module lpct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpct_pkg::cmd_type cmd
);
   import lpct_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = accept;
      cmd.lookup  = (state_ff == ST_LOOKUP);
      cmd.commit  = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // a new transaction may enter in the same cycle the last one retires
            if (out_free) state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/lpct_dpath.sv @@
// Tag store, valid bits, recency ranks, lookup registers and result register.
module lpct_dpath #(
   parameter int NUM_SLOTS       = 16,
   parameter int PAGE_BYTES_LOG2 = 12,
   parameter int ADDRESS_BITS    = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lpct_pkg::cmd_type                     cmd,
   input  logic [lpct_pkg::BYTE_OFFSET_W-1:0]    req_byte_offset,
   output lpct_pkg::rsp_payload_type             rsp_payload
);
   import lpct_pkg::*;

   localparam int AW_EFF = (ADDRESS_BITS < BYTE_OFFSET_W) ? ADDRESS_BITS : BYTE_OFFSET_W;
   localparam int TAG_W  = (AW_EFF > PAGE_BYTES_LOG2) ? (AW_EFF - PAGE_BYTES_LOG2) : 1;
   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam logic [BYTE_OFFSET_W-1:0] ADDR_MASK =
      {BYTE_OFFSET_W{1'b1}} >> (BYTE_OFFSET_W - AW_EFF);
   localparam logic [BYTE_OFFSET_W-1:0] OFF_MASK =
      (BYTE_OFFSET_W'(1) << PAGE_BYTES_LOG2) - BYTE_OFFSET_W'(1);
   localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(NUM_SLOTS - 1);

   logic [BYTE_OFFSET_W-1:0] addr_ff;
   logic [TAG_W-1:0]         page;

   logic [NUM_SLOTS-1:0]     valid_ff, valid_in;
   logic [TAG_W-1:0]         tag_ff  [NUM_SLOTS];
   logic [TAG_W-1:0]         tag_in  [NUM_SLOTS];
   logic [IDX_W-1:0]         rank_ff [NUM_SLOTS];
   logic [IDX_W-1:0]         rank_in [NUM_SLOTS];

   logic [NUM_SLOTS-1:0]     match;
   logic [IDX_W-1:0]         hit_idx;
   logic [IDX_W-1:0]         lru_idx;
   logic                     hit_ff;
   logic [IDX_W-1:0]         sel_ff;

   logic [IDX_W-1:0]         old_rank;
   logic                     ev_valid;
   logic [BYTE_OFFSET_W-1:0] ev_base;

   rsp_payload_type          out_ff, out_in;

   assign page = TAG_W'(addr_ff >> PAGE_BYTES_LOG2);

   // parallel tag compare; lowest matching index wins
   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == page);
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) hit_idx = IDX_W'(i);
      end
      // ranks are a permutation, so exactly one slot carries the LRU rank
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (rank_ff[i] == LRU_RANK) lru_idx = IDX_W'(i);
      end
   end

   assign old_rank = rank_ff[sel_ff];
   assign ev_valid = !hit_ff && valid_ff[sel_ff];
   assign ev_base  = ev_valid ?
                     ((BYTE_OFFSET_W'(tag_ff[sel_ff]) << PAGE_BYTES_LOG2) & ADDR_MASK) : '0;

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tag_in[i]  = tag_ff[i];
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (IDX_W'(i) == sel_ff) begin
               rank_in[i] = '0;
               if (!hit_ff) begin
                  valid_in[i] = 1'b1;
                  tag_in[i]   = page;
               end
            end else if (rank_ff[i] < old_rank) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      out_in                   = out_ff;
      out_in.hit               = hit_ff;
      out_in.slot              = SLOT_W'(sel_ff);
      out_in.page_base         = addr_ff & ~OFF_MASK;
      out_in.offset_in_page    = OFFSET_IN_PAGE_W'(addr_ff & OFF_MASK);
      out_in.fill_needed       = !hit_ff;
      out_in.evict_valid       = ev_valid;
      out_in.evicted_page_base = ev_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (cmd.capture) addr_ff <= req_byte_offset & ADDR_MASK;
      if (cmd.lookup) begin
         hit_ff <= |match;
         sel_ff <= (|match) ? hit_idx : lru_idx;
      end
      if (cmd.commit) out_ff <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule

@@ rtl/core/lru_page_cache_tags.sv @@
// Top level of the fully associative LRU page cache tag block.
//
//   channel   direction   handshake            payload
//   req_ch    in          valid/ready (sink)   byte_offset
//   rsp_ch    out         valid/ready (source) hit, slot, page_base, offset_in_page,
//                                              fill_needed, evict_valid, evicted_page_base
//
// A transaction passes through capture, a registered parallel tag match and LRU pick, and
// a commit of the rank/tag update into the result register; a new transaction is
// accepted only in the commit step of the last one, not while it is in lookup.
// Reset clears the valid bits and returns ranks to slot order directly, with no sweep.
// A held result stalls the commit step, and with it the next request.
module lru_page_cache_tags #(
   parameter int NUM_SLOTS       = 16,
   parameter int PAGE_BYTES_LOG2 = 12,
   parameter int ADDRESS_BITS    = 48
) (
   input  logic     clock,
   input  logic     reset,
   lpct_req_if.sink   req_ch,
   lpct_rsp_if.source rsp_ch
);
   import lpct_pkg::*;

   cmd_type         cmd;
   rsp_payload_type payload;

   lpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   lpct_dpath #(
      .NUM_SLOTS       (NUM_SLOTS),
      .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2),
      .ADDRESS_BITS    (ADDRESS_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_byte_offset (req_ch.byte_offset),
      .rsp_payload     (payload)
   );

   assign rsp_ch.hit               = payload.hit;
   assign rsp_ch.slot              = payload.slot;
   assign rsp_ch.page_base         = payload.page_base;
   assign rsp_ch.offset_in_page    = payload.offset_in_page;
   assign rsp_ch.fill_needed       = payload.fill_needed;
   assign rsp_ch.evict_valid       = payload.evict_valid;
   assign rsp_ch.evicted_page_base = payload.evicted_page_base;

endmodule

@@ rtl/core/lpct_checker.sv @@
// Port-level checks for the LRU page cache tag block, bound to the top level.
module lpct_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_hit,
   input logic                                  rsp_fill_needed,
   input logic                                  rsp_evict_valid,
   input logic [lpct_pkg::BYTE_OFFSET_W-1:0]    rsp_page_base,
   input logic [lpct_pkg::BYTE_OFFSET_W-1:0]    rsp_evicted_page_base
);
   import lpct_pkg::*;

   // a stalled result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_base)
                                  && $stable(rsp_evicted_page_base) && $stable(rsp_hit))
      else $error("result changed while stalled");

   a_fill_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_needed == !rsp_hit))
      else $error("fill_needed disagrees with hit");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evict_valid |-> !rsp_hit && (rsp_evicted_page_base[3:0] == 4'd0))
      else $error("eviction reported on a hit or unaligned");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_valid |-> (rsp_evicted_page_base == '0))
      else $error("evicted base nonzero without eviction");

endmodule

bind lru_page_cache_tags lpct_checker u_lpct_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_hit               (rsp_ch.hit),
   .rsp_fill_needed       (rsp_ch.fill_needed),
   .rsp_evict_valid       (rsp_ch.evict_valid),
   .rsp_page_base         (rsp_ch.page_base),
   .rsp_evicted_page_base (rsp_ch.evicted_page_base)
);
